>>> src/itt_pkg.sv
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types and constants of the interaction tracking table.
// ----------------------------------------------------------------------------
`default_nettype none

package itt_pkg;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [63:0] HEADER_RST   = 64'hFF02_0103_4B66_C101;
  localparam logic [31:0] AGE_RST      = 32'd100000000;
  localparam logic [10:0] LEN_RST      = 11'd16;

  // Seconds from microseconds: (span * DUR_RECIP) >> DUR_SHIFT, exact for
  // every 32-bit span.
  localparam logic [31:0] DUR_RECIP    = 32'd1125899907;
  localparam int unsigned DUR_SHIFT    = 50;

  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_AGE    = 2'd1;
  localparam logic [1:0] REG_LEN    = 2'd2;

  localparam logic [1:0] STATUS_LIMIT = 2'd1;
  localparam logic [7:0] CYC_MAX      = 8'hFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [7:0] RESPOND_HITS = 8'd2;

  typedef enum logic [2:0] {
    KIND_ID       = 3'd0,
    KIND_NOT_ID   = 3'd1,
    KIND_IGNORED  = 3'd2,
    KIND_LOG      = 3'd3,
    KIND_FLUSHEND = 3'd4
  } kind_e;

  typedef struct packed {
    logic               operation;
    logic [1:0]         packet_status;
    logic [10:0]        packet_length;
    logic [63:0]        header;
    logic [63:0]        ident;
    logic signed [7:0]  rssi;
    logic [31:0]        timestamp_us;
    logic               transmit_pending;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic               respond;
    logic               table_full;
    logic [11:0]        log_id_sum;
    logic [31:0]        start_time_us;
    logic [12:0]        duration_s;
    logic signed [7:0]  mean_rssi;
    logic signed [7:0]  max_rssi;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               in_use;
    logic [63:0]        hdr;
    logic [63:0]        ident;
    logic [31:0]        first;
    logic [31:0]        newest;
    logic signed [15:0] sum;
    logic [15:0]        count;
    logic signed [7:0]  maxr;
    logic [7:0]         cyc;
  } slot_t;

  // Sum of all sixteen packet bytes, one byte pair per step.
  function automatic logic [11:0] byte_sum(input logic [63:0] hdr, input logic [63:0] id);
    logic [11:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 12'(hdr[i*8 +: 8]) + 12'(id[i*8 +: 8]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/itt_cell.sv
// ----------------------------------------------------------------------------
// itt_cell
// One slot of the table ring; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module itt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire itt_pkg::slot_t entry_i,
  output itt_pkg::slot_t     entry_o
);

  logic           in_use_q;
  itt_pkg::slot_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
    end else if (shift_i) begin
      in_use_q <= entry_i.in_use;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o        = data_q;
    entry_o.in_use = in_use_q;
  end

endmodule

`default_nettype wire

>>> src/itt_div.sv
// ----------------------------------------------------------------------------
// itt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itt_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [19:0] divisor_i,
  output logic             busy_o,
  output logic [31:0]      quotient_o
);

  logic        busy_q, busy_d;
  logic [4:0]  step_q, step_d;
  logic [20:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [20:0] dvs_q, dvs_d;
  logic [20:0] trial;
  logic        ge;

  assign trial = {rem_q[19:0], quo_q[31]};
  assign ge    = (trial >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = {1'b0, divisor_i};
    end else if (busy_q) begin
      rem_d  = ge ? (trial - dvs_q) : trial;
      quo_d  = {quo_q[30:0], ge};
      step_d = step_q + 5'd1;
      if (step_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/interaction_tracking_table.sv
// ----------------------------------------------------------------------------
// interaction_tracking_table
// Slot table that follows radio ID-packet interactions and logs them.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid_i/in_ready_o with an itt_pkg::in_t payload.
//   Each item is a received packet or an end-of-wake-cycle flush. Results leave
//   on out_valid_o/out_ready_i as itt_pkg::out_t; the final result of an item
//   carries last = 1.
//   The slots sit in a ring of cells. Processing rotates the ring past one head
//   unit, one slot per cycle unless a flush holds it for the divider or the
//   output, and a full pass leaves the ring in its original order.
//   The block takes one item at a time:
//     - bad status or non-ID packet: no pass over the ring;
//     - ID packet: one pass looks for a hit, a miss a second to claim a slot;
//     - flush: one pass; each logged slot holds the ring while the bit-serial
//       divider forms the mean rssi; the duration comes from a reciprocal
//       multiply while that divider runs.
//   A finished result waits in the output register; when the receiver stalls,
//   a pending log entry holds the ring still until the register frees up.
//   Reset frees every slot and loads the default configuration. Configuration
//   writes on cfg_we_i land at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module interaction_tracking_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire itt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output itt_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [63:0]   cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HIT   = 6'b000010,
    S_CLAIM = 6'b000100,
    S_FLUSH = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  localparam logic [itt_pkg::CNT_W-1:0] CNT_END = itt_pkg::CNT_W'(itt_pkg::SLOTS - 1);

  state_e                    state_q, state_d;
  logic [itt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      hit_q, hit_d, claim_q, claim_d;
  itt_pkg::in_t              item_q, item_d;
  itt_pkg::out_t             res_q, res_d, out_q, out_d;
  logic                      out_valid_q, out_valid_d;
  logic [11:0]               idsum_q, idsum_d;
  logic [31:0]               span_q, span_d;

  logic [63:0] hdr_cfg_q;
  logic [31:0] age_cfg_q;
  logic [10:0] len_cfg_q;

  itt_pkg::slot_t slot_q [itt_pkg::SLOTS];
  itt_pkg::slot_t head, head_d, upd, fresh;
  logic           shift;

  logic        match, aged, out_free, cnt_end;
  logic [16:0] sum_wide;
  logic [15:0] sum_sat, mag;
  logic        div_start, busy_b;
  logic [31:0] quo_b;
  logic [63:0] dur_prod;
  logic [7:0]  mean;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cfg_q <= itt_pkg::HEADER_RST;
      age_cfg_q <= itt_pkg::AGE_RST;
      len_cfg_q <= itt_pkg::LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == itt_pkg::REG_HEADER) hdr_cfg_q <= cfg_data_i;
      if (cfg_idx_i == itt_pkg::REG_AGE)    age_cfg_q <= cfg_data_i[31:0];
      if (cfg_idx_i == itt_pkg::REG_LEN)    len_cfg_q <= cfg_data_i[10:0];
    end
  end

  // Ring of slot cells: each takes its upper neighbor; the last takes the
  // entry coming out of the head unit.
  for (genvar k = 0; k < itt_pkg::SLOTS; k++) begin : g_cell
    itt_pkg::slot_t nxt;
    if (k == itt_pkg::SLOTS - 1) begin : g_tail
      assign nxt = head_d;
    end else begin : g_mid
      assign nxt = slot_q[k+1];
    end
    itt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (slot_q[k])
    );
  end

  assign head = slot_q[0];

  // Head unit: match, hit update and new entry
  assign match = head.in_use && (head.hdr == item_q.header) && (head.ident == item_q.ident);
  assign sum_wide = {head.sum[15], head.sum} + {{9{item_q.rssi[7]}}, item_q.rssi};

  always_comb begin
    unique case (sum_wide[16:15])
      2'b01:   sum_sat = 16'h7FFF;
      2'b10:   sum_sat = 16'h8000;
      default: sum_sat = sum_wide[15:0];
    endcase
  end

  always_comb begin
    upd        = head;
    upd.maxr   = (item_q.rssi > head.maxr) ? item_q.rssi : head.maxr;
    upd.newest = item_q.timestamp_us;
    upd.cyc    = (head.cyc == itt_pkg::CYC_MAX) ? head.cyc : head.cyc + 8'd1;
    upd.sum    = sum_sat;
    upd.count  = (head.count == itt_pkg::COUNT_MAX) ? head.count : head.count + 16'd1;
  end

  always_comb begin
    fresh.in_use = 1'b1;
    fresh.hdr    = item_q.header;
    fresh.ident  = item_q.ident;
    fresh.first  = item_q.timestamp_us;
    fresh.newest = item_q.timestamp_us;
    fresh.sum    = {{8{item_q.rssi[7]}}, item_q.rssi};
    fresh.count  = 16'd1;
    fresh.maxr   = item_q.rssi;
    fresh.cyc    = 8'd1;
  end

  assign aged = ((item_q.timestamp_us - head.first) >= age_cfg_q);

  // Duration in seconds by reciprocal multiply of the registered span
  assign dur_prod = span_q * itt_pkg::DUR_RECIP;

  // Divider for the magnitude of the mean rssi
  assign mag = head.sum[15] ? 16'(-head.sum) : head.sum;

  itt_div u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({16'd0, mag}),
    .divisor_i  ({4'd0, head.count}),
    .busy_o     (busy_b),
    .quotient_o (quo_b)
  );

  always_comb begin
    if (head.count == 16'd0) begin
      mean = 8'd0;
    end else if (head.sum[15]) begin
      mean = 8'(-quo_b[7:0]);
    end else begin
      mean = quo_b[7:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_end  = (cnt_q == CNT_END);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    claim_d     = claim_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idsum_d     = idsum_q;
    span_d      = span_q;
    shift       = 1'b0;
    head_d      = head;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d     = in_data_i;
          cnt_d      = '0;
          hit_d      = 1'b0;
          claim_d    = 1'b0;
          res_d      = '0;
          res_d.last = 1'b1;
          if (in_data_i.operation) begin
            state_d = S_FLUSH;
          end else begin
            res_d.respond = in_data_i.transmit_pending;
            if (in_data_i.packet_status > itt_pkg::STATUS_LIMIT) begin
              res_d.kind = itt_pkg::KIND_IGNORED;
              state_d    = S_FIN;
            end else if ((in_data_i.packet_length != len_cfg_q) ||
                         (in_data_i.header != hdr_cfg_q)) begin
              res_d.kind = itt_pkg::KIND_NOT_ID;
              state_d    = S_FIN;
            end else begin
              res_d.kind = itt_pkg::KIND_ID;
              state_d    = S_HIT;
            end
          end
        end
      end
      S_HIT: begin
        shift = 1'b1;
        if (match) begin
          head_d        = upd;
          hit_d         = 1'b1;
          res_d.respond = item_q.transmit_pending || (upd.cyc < itt_pkg::RESPOND_HITS);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_end) begin
          cnt_d   = '0;
          state_d = (hit_q || match) ? S_FIN : S_CLAIM;
        end
      end
      S_CLAIM: begin
        shift = 1'b1;
        if (!claim_q && !head.in_use) begin
          head_d        = fresh;
          claim_d       = 1'b1;
          res_d.respond = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_end) begin
          cnt_d = '0;
          if (!claim_q && head.in_use) begin
            res_d.table_full = 1'b1;
          end
          state_d = S_FIN;
        end
      end
      S_FLUSH: begin
        if (head.in_use && aged) begin
          // hold the ring while the divider runs
          div_start = 1'b1;
          idsum_d   = itt_pkg::byte_sum(head.hdr, head.ident);
          span_d    = head.newest - head.first;
          state_d   = S_DIV;
        end else begin
          shift      = 1'b1;
          head_d.cyc = 8'd0;
          cnt_d      = cnt_q + 1'b1;
          if (cnt_end) begin
            cnt_d      = '0;
            res_d      = '0;
            res_d.kind = itt_pkg::KIND_FLUSHEND;
            res_d.last = 1'b1;
            state_d    = S_FIN;
          end
        end
      end
      S_DIV: begin
        if (!busy_b && out_free) begin
          out_d               = '0;
          out_d.kind          = itt_pkg::KIND_LOG;
          out_d.log_id_sum    = idsum_q;
          out_d.start_time_us = head.first;
          out_d.duration_s    = dur_prod[itt_pkg::DUR_SHIFT +: 13];
          out_d.mean_rssi     = mean;
          out_d.max_rssi      = head.maxr;
          out_valid_d         = 1'b1;
          // drop the slot as it passes the head
          shift         = 1'b1;
          head_d.in_use = 1'b0;
          head_d.cyc    = 8'd0;
          cnt_d         = cnt_q + 1'b1;
          state_d       = S_FLUSH;
          if (cnt_end) begin
            cnt_d      = '0;
            res_d      = '0;
            res_d.kind = itt_pkg::KIND_FLUSHEND;
            res_d.last = 1'b1;
            state_d    = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      claim_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      claim_q     <= claim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    res_q   <= res_d;
    out_q   <= out_d;
    idsum_q <= idsum_d;
    span_q  <= span_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/itt_checker.sv
// ----------------------------------------------------------------------------
// itt_port_checker
// Port-level checks of the interaction tracking table.
// ----------------------------------------------------------------------------
`default_nettype none

module itt_port_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire itt_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire itt_pkg::out_t out_data_o,
  input wire logic          cfg_we_i,
  input wire logic [1:0]    cfg_idx_i,
  input wire logic [63:0]   cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new item taken before results of the previous one");

  a_only_log_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.kind == itt_pkg::KIND_LOG)
    else $error("non-final result that is not a log entry");

  a_log_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == itt_pkg::KIND_LOG |->
      !out_data_o.respond && !out_data_o.table_full && !out_data_o.last)
    else $error("log entry with reply, full or last flag");

endmodule

bind interaction_tracking_table itt_port_checker u_itt_checker (.*);

`default_nettype wire

>>> verif/itt_checker.sv
// ----------------------------------------------------------------------------
// itt_checker
// Watches both channels and the configuration port of the interaction
// tracking table, predicts every result item and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module itt_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  wire itt_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_ready_i,
  input  wire itt_pkg::out_t out_data_i,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [63:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o
);
  import itt_pkg::*;

  typedef struct {
    logic               used;
    logic [63:0]        hdr;
    logic [63:0]        ident;
    logic [31:0]        first;
    logic [31:0]        newest;
    int                 sum;
    int unsigned        count;
    int                 maxr;
    int unsigned        cyc;
  } track_t;

  track_t      tracks[SLOTS];
  logic [63:0] hdr_cfg;
  logic [31:0] age_cfg;
  logic [10:0] len_cfg;
  out_t        expected_q[$];

  assign pending_o = expected_q.size();

  function automatic out_t blank(kind_e k, logic resp, logic full, logic lst);
    out_t o;
    o = '0;
    o.kind = k;
    o.respond = resp;
    o.table_full = full;
    o.last = lst;
    return o;
  endfunction

  function automatic int unsigned bytes_of(logic [63:0] v);
    int unsigned s;
    s = 0;
    for (int b = 0; b < 8; b++) s += v[b*8 +: 8];
    return s;
  endfunction

  // Advance the table by one item and queue the results it causes.
  task automatic predict_results(in_t it);
    int          hit;
    int          free_slot;
    int          s;
    int          r;
    out_t        o;
    logic [31:0] age;
    hit = -1;
    free_slot = -1;
    r = it.rssi;
    if (it.operation) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (tracks[i].used) begin
          tracks[i].cyc = 0;
          age = it.timestamp_us - tracks[i].first;
          if (age >= age_cfg) begin
            o = blank(KIND_LOG, 1'b0, 1'b0, 1'b0);
            o.log_id_sum = 12'(bytes_of(tracks[i].hdr) + bytes_of(tracks[i].ident));
            o.start_time_us = tracks[i].first;
            o.duration_s = 13'((tracks[i].newest - tracks[i].first) / 32'd1000000);
            o.mean_rssi = (tracks[i].count == 0) ? 8'sd0 :
                          8'(tracks[i].sum / int'(tracks[i].count));
            o.max_rssi = 8'(tracks[i].maxr);
            expected_q.push_back(o);
            tracks[i].used = 1'b0;
          end
        end
      end
      expected_q.push_back(blank(KIND_FLUSHEND, 1'b0, 1'b0, 1'b1));
      return;
    end
    if (it.packet_status > STATUS_LIMIT) begin
      expected_q.push_back(blank(KIND_IGNORED, it.transmit_pending, 1'b0, 1'b1));
      return;
    end
    if (it.packet_length != len_cfg || it.header != hdr_cfg) begin
      expected_q.push_back(blank(KIND_NOT_ID, it.transmit_pending, 1'b0, 1'b1));
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && tracks[i].used && tracks[i].hdr == it.header &&
          tracks[i].ident == it.ident) hit = i;
      if (free_slot < 0 && !tracks[i].used) free_slot = i;
    end
    if (hit >= 0) begin
      if (r > tracks[hit].maxr) tracks[hit].maxr = r;
      tracks[hit].newest = it.timestamp_us;
      if (tracks[hit].cyc < 255) tracks[hit].cyc++;
      s = tracks[hit].sum + r;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      tracks[hit].sum = s;
      if (tracks[hit].count < 65535) tracks[hit].count++;
      expected_q.push_back(blank(KIND_ID, it.transmit_pending | (tracks[hit].cyc < 2),
                                 1'b0, 1'b1));
    end else if (free_slot >= 0) begin
      tracks[free_slot] = '{1'b1, it.header, it.ident, it.timestamp_us, it.timestamp_us,
                            r, 1, r, 1};
      expected_q.push_back(blank(KIND_ID, 1'b1, 1'b0, 1'b1));
    end else begin
      expected_q.push_back(blank(KIND_ID, it.transmit_pending, 1'b1, 1'b1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      hdr_cfg <= HEADER_RST;
      age_cfg <= AGE_RST;
      len_cfg <= LEN_RST;
      for (int i = 0; i < SLOTS; i++) tracks[i] = '{1'b0, 0, 0, 0, 0, 0, 0, 0, 0};
      expected_q.delete();
      fail_count_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEADER: hdr_cfg <= cfg_data_i;
          REG_AGE: age_cfg <= cfg_data_i[31:0];
          REG_LEN: len_cfg <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_data_i) begin
            if (fail_count_o < 10) $display("mismatch: expected %p, got %p", want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_results(in_data_i);
    end
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives packet and flush items into the interaction tracking table with
// random gaps and stalls, rewrites its registers between phases, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import itt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending;
  int          results;

  // Current register values, mirrored so stimulus can form ID packets.
  logic [63:0] cur_hdr;
  logic [31:0] cur_age;
  logic [10:0] cur_len;
  logic [63:0] known_ids[$];
  logic [31:0] now_us;
  int          items_sent;
  int          idle_pct;      // chance of a gap, percent; zero for a calm stretch
  bit          hold_receiver; // long receiver stall for the pressure phase

  interaction_tracking_table i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  itt_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random, or hold off entirely during the pressure phase.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_receiver && ($urandom_range(99) >= idle_pct);
    end
  end

  // Hand one item to the block; keep it steady until accepted, maybe idle after.
  task automatic send_item(in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      REG_HEADER: cur_hdr = val;
      REG_AGE: cur_age = val[31:0];
      default: cur_len = val[10:0];
    endcase
  endtask

  // Drop valid and wait for every outstanding result, then let the table settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * SLOTS + 40) @(posedge clk);
  endtask

  function automatic in_t id_packet(logic [63:0] id, logic [31:0] t);
    in_t it;
    it = '0;
    it.operation = 1'b0;
    it.packet_status = 2'($urandom_range(1));
    it.packet_length = cur_len;
    it.header = cur_hdr;
    it.ident = id;
    it.rssi = 8'($urandom);
    it.timestamp_us = t;
    it.transmit_pending = 1'($urandom);
    return it;
  endfunction

  function automatic in_t flush_item(logic [31:0] t);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.operation = 1'b1;
    it.timestamp_us = t;
    return it;
  endfunction

  // Mostly valid ID packets from a small population of senders, some noise,
  // and a flush now and then; time moves forward in random steps.
  function automatic in_t random_item();
    in_t         it;
    int          pick;
    logic [63:0] id;
    pick = $urandom_range(99);
    now_us = now_us + $urandom_range(0, 3000000);
    if (pick < 10) return flush_item(now_us);
    if (pick < 20) begin
      it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.operation = 1'b0;
      it.packet_status = 2'($urandom_range(3));
      if (it.packet_status == 2'd3 && $urandom_range(1)) it.packet_status = 2'd2;
      return it;
    end
    if (known_ids.size() == 0 || $urandom_range(99) < 30) begin
      id = {$urandom, $urandom};
      known_ids.push_back(id);
    end else begin
      id = known_ids[$urandom_range(known_ids.size() - 1)];
    end
    it = id_packet(id, now_us);
    if (pick < 24) it.header[$urandom_range(63)] ^= 1'b1;
    else if (pick < 27) it.packet_length = cur_len ^ 11'(1 << $urandom_range(10));
    return it;
  endfunction

  initial begin
    in_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_HEADER;
    cfg_data = '0;
    cur_hdr = HEADER_RST;
    cur_age = AGE_RST;
    cur_len = LEN_RST;
    now_us = 32'd0;
    items_sent = 0;
    idle_pct = 13;
    hold_receiver = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad status, non-ID packets, new slot, hits with both pending values,
    // extreme rssi, then flushes before and after the age.
    it = id_packet(64'h0, 32'd0); it.packet_status = 2'd2; send_item(it);
    it = id_packet(64'h0, 32'd0); it.packet_status = 2'd3; send_item(it);
    it = id_packet(64'h0, 32'd0); it.packet_length = 11'd2047; send_item(it);
    it = id_packet(64'h0, 32'd0); it.header = ~cur_hdr; send_item(it);
    it = id_packet('1, 32'hFFFF_FFF0); it.rssi = -8'sd128; send_item(it);
    for (int k = 0; k < 4; k++) begin
      it = id_packet('1, 32'd5000000 * k); it.rssi = 8'sd127;
      it.transmit_pending = k[0]; send_item(it);
    end
    it = id_packet(64'h0, 32'd7); it.rssi = -8'sd128; send_item(it);
    send_item(flush_item(32'd1));
    it = id_packet('1, 32'd99000000); it.rssi = 8'sd0; send_item(it);
    send_item(flush_item(32'hFFFF_FFFF));
    send_item(flush_item(32'd0));
    drain();

    // Extreme rssi with the shortest age limit, a zero packet length and an
    // all-zero header.
    write_reg(REG_AGE, 32'd0);
    write_reg(REG_LEN, 11'd0);
    write_reg(REG_HEADER, 64'h0);
    for (int k = 0; k < 6; k++) begin
      it = id_packet(64'h1234, 32'(k)); it.rssi = (k < 4) ? 8'sd127 : -8'sd128;
      send_item(it);
    end
    it = id_packet(64'h5678, 32'd0); it.rssi = -8'sd128;
    for (int k = 0; k < 4; k++) send_item(it);
    send_item(flush_item(32'd3));
    drain();

    // Fill the table past capacity, then flush twice with the largest age limit.
    write_reg(REG_AGE, 32'hFFFF_FFFF);
    write_reg(REG_LEN, 11'd2047);
    write_reg(REG_HEADER, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < SLOTS + 3; k++) send_item(id_packet(64'(k) << 3, 32'(k * 1000)));
    send_item(flush_item(32'd0));
    send_item(flush_item(32'hFFFF_FFFF));
    drain();

    // Pressure: the receiver stops while the sender keeps offering items.
    write_reg(REG_AGE, 32'd1);
    write_reg(REG_LEN, LEN_RST);
    write_reg(REG_HEADER, HEADER_RST);
    fork
      begin
        hold_receiver = 1'b1;
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end
      for (int k = 0; k < 20; k++) send_item(random_item());
    join
    drain();

    // Random phases with different register settings and idling.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_AGE, (phase == 0) ? AGE_RST : 32'($urandom_range(20000000)));
      write_reg(REG_HEADER, (phase == 3) ? 64'h0123_4567_89AB_CDEF : HEADER_RST);
      write_reg(REG_LEN, (phase == 2) ? 11'd24 : LEN_RST);
      known_ids.delete();
      idle_pct = (phase == 1) ? 0 : 13;
      for (int k = 0; k < 33; k++) send_item(random_item());
      send_item(flush_item(now_us + 32'd500000000));
      drain();
    end

    $display("Covered %0d input items and %0d result items over several register settings,",
             items_sent, results);
    $display("including full table, extreme rssi, stalls and aged-out logging.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

>>> interaction_tracking_table.f
src/itt_pkg.sv
src/itt_cell.sv
src/itt_div.sv
src/interaction_tracking_table.sv
src/itt_checker.sv
verif/itt_checker.sv
verif/tb.sv
